// File: rtl/holonomic_pose_pid_controller_macros.svh
// Assertion macros for the go-to-pose controller
`ifndef HOLONOMIC_POSE_PID_CONTROLLER_MACROS_SVH
`define HOLONOMIC_POSE_PID_CONTROLLER_MACROS_SVH

// same-cycle implication, reset masks the check
`define HPPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hppc_pkg.sv
// Types, constants and helpers for the go-to-pose PID controller
package hppc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 60;
  localparam int unsigned GainW    = 20;
  localparam int unsigned XyW      = 36;  // CORDIC x/y width
  localparam int unsigned ZW       = 28;  // CORDIC angle width, 2^-24 rad
  localparam int unsigned MulAW    = 36;
  localparam int unsigned MulBW    = 33;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned YawW     = 17;  // Q3.13 yaw and heading error
  localparam int unsigned StepW    = 5;
  localparam int unsigned AtanLen  = 24;

  localparam logic signed [ZW-1:0]    PiQ24     = 28'sd52707179;
  localparam logic signed [ZW-1:0]    HalfPiQ24 = 28'sd26353589;
  localparam logic signed [MulBW-1:0] InvGainQ30 = 33'sd652032874;
  localparam logic signed [ProdW-1:0] KiHiLim   = 69'sd274877906944;  // 2^38

  // register indices
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_POS_TOL = 3'd3,
    REG_ANG_TOL = 3'd4
  } hppc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUAT,
    ST_VSETUP,
    ST_VEC,
    ST_YAW,
    ST_ERR,
    ST_PID,
    ST_DIST,
    ST_RSETUP,
    ST_ROT,
    ST_SCALE,
    ST_DONE
  } hppc_state_e;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_qx;
    logic signed [15:0] pose_qy;
    logic signed [15:0] pose_qz;
    logic signed [15:0] pose_qw;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_qx;
    logic signed [15:0] goal_qy;
    logic signed [15:0] goal_qz;
    logic signed [15:0] goal_qw;
  } hppc_in_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] angular_rate;
    logic               reached;
    logic               saturated;
  } hppc_out_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] val;
  } hppc_sat_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic signed [ZW-1:0] atan_q24(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clip a wide signed value to 32 bits
  function automatic hppc_sat_t sat32(input logic signed [71:0] v);
    hppc_sat_t r;
    if (v > 72'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = 32'sh80000000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

  // one 20-bit gain out of a packed triple
  function automatic logic [GainW-1:0] gain_of(input logic [CfgDataW-1:0] g,
                                               input logic [1:0] a);
    logic [GainW-1:0] r;
    unique case (a)
      2'd0:    r = g[19:0];
      2'd1:    r = g[39:20];
      2'd2:    r = g[59:40];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/holonomic_pose_pid_controller.sv
// Go-to-pose PID controller: yaw extraction, per-axis PID, body-frame rotation
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i  in_ready_o  in_data_i    | pose and goal words in
//   out     | out_valid_o out_ready_i out_data_o   | velocity command words out
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | register writes
//
// Each word is worked on in turn through the one shared CORDIC stage and the one
// shared 36x33 multiplier; a reached goal skips the body-frame rotation, and a
// quaternion that gives a zero vector skips the vectoring. in_ready_o is high
// only when idle.
// A finished word sits in the output register; the next word may be taken and
// worked on meanwhile, and the final load waits for that register to drain.
// Reset clears the integrators, previous errors and gains, and restores the
// tolerance defaults.
module holonomic_pose_pid_controller #(
  parameter int unsigned CORDIC_STEPS   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  hppc_pkg::hppc_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output hppc_pkg::hppc_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hppc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hppc_pkg::CfgDataW-1:0] cfg_data_i
);
  import hppc_pkg::*;

  `include "holonomic_pose_pid_controller_macros.svh"

  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);

  hppc_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [1:0]       axis_q, axis_d;
  logic             goal_q, goal_d;

  hppc_in_t in_q;
  logic [CfgDataW-1:0] kp_q, ki_q, kd_q;
  logic [15:0]         ptol_q;
  logic [14:0]         atol_q;

  logic signed [XyW-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic signed [ZW-1:0]    cz_q, cz_d;
  logic signed [63:0]      acc_q, acc_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [YawW-1:0]  yaw_p_q, yaw_p_d, yaw_g_q, yaw_g_d, eth_q, eth_d;
  logic signed [31:0]      err_q [3];
  logic signed [31:0]      err_d [3];
  logic signed [47:0]      integ_q [3];
  logic signed [47:0]      integ_d [3];
  logic signed [31:0]      prev_q [3];
  logic signed [31:0]      prev_d [3];
  logic signed [31:0]      ctrl_q [3];
  logic signed [31:0]      ctrl_d [3];
  logic [2:0]              cclip_q, cclip_d;
  logic                    flag_q, flag_d, reached_q, reached_d;
  logic signed [31:0]      vx_q, vx_d, vy_q, vy_d;
  hppc_out_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;

  // shared CORDIC stage signals
  logic signed [XyW-1:0] sx, sy;
  logic                  arm_a;
  logic signed [ZW-1:0]  at;

  // PID helpers
  logic signed [31:0] e_sel, p_sel;
  logic signed [48:0] isum;
  logic signed [32:0] ediff;
  logic [GainW-1:0]   kp_s, ki_s, kd_s;
  logic signed [39:0] khi;
  logic signed [63:0] pid_sum, ctrl_full;

  // other scratch
  logic signed [15:0] qx, qy, qz, qw;
  logic signed [32:0] dx, dy;
  logic signed [ZW-1:0] zr;
  logic signed [YawW:0] eth_w;
  logic [YawW-1:0]      eth_abs;
  logic [63:0]          d2;
  hppc_sat_t            s_a, s_b;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign e_sel = err_q[axis_q];
  assign p_sel = prev_q[axis_q];
  assign kp_s  = gain_of(kp_q, axis_q);
  assign ki_s  = gain_of(ki_q, axis_q);
  assign kd_s  = gain_of(kd_q, axis_q);
  assign ediff = {e_sel[31], e_sel} - {p_sel[31], p_sel};
  assign isum  = {integ_q[axis_q][47], integ_q[axis_q]} + {{17{e_sel[31]}}, e_sel};

  assign qx = goal_q ? in_q.goal_qx : in_q.pose_qx;
  assign qy = goal_q ? in_q.goal_qy : in_q.pose_qy;
  assign qz = goal_q ? in_q.goal_qz : in_q.pose_qz;
  assign qw = goal_q ? in_q.goal_qw : in_q.pose_qw;

  // shared CORDIC micro-rotation
  assign sx    = cx_q >>> step_q;
  assign sy    = cy_q >>> step_q;
  assign at    = atan_q24(step_q);
  assign arm_a = (state_q == ST_VEC) ? (cy_q > 0) : (cz_q < 0);

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_QUAT: begin
        unique case (step_q)
          5'd0:    begin mul_a = MulAW'(qz); mul_b = MulBW'(qw); end
          5'd1:    begin mul_a = MulAW'(qx); mul_b = MulBW'(qy); end
          5'd2:    begin mul_a = MulAW'(qy); mul_b = MulBW'(qy); end
          5'd3:    begin mul_a = MulAW'(qz); mul_b = MulBW'(qz); end
          default: ;
        endcase
      end
      ST_PID: begin
        unique case (step_q)
          5'd0:    begin mul_a = MulAW'(e_sel); mul_b = MulBW'(signed'({1'b0, kp_s})); end
          5'd1:    begin mul_a = MulAW'(ediff); mul_b = MulBW'(signed'({1'b0, kd_s})); end
          5'd2: begin
            mul_a = MulAW'(signed'({1'b0, integ_q[axis_q][23:0]}));
            mul_b = MulBW'(signed'({1'b0, ki_s}));
          end
          5'd3: begin
            mul_a = MulAW'(signed'(integ_q[axis_q][47:24]));
            mul_b = MulBW'(signed'({1'b0, ki_s}));
          end
          default: ;
        endcase
      end
      ST_DIST: begin
        unique case (step_q)
          5'd0:    begin mul_a = MulAW'(err_q[0]); mul_b = MulBW'(err_q[0]); end
          5'd1:    begin mul_a = MulAW'(err_q[1]); mul_b = MulBW'(err_q[1]); end
          5'd2: begin
            mul_a = MulAW'(signed'({1'b0, ptol_q}));
            mul_b = MulBW'(signed'({1'b0, ptol_q}));
          end
          default: ;
        endcase
      end
      ST_SCALE: begin
        unique case (step_q)
          5'd0:    begin mul_a = cx_q; mul_b = InvGainQ30; end
          5'd1:    begin mul_a = cy_q; mul_b = InvGainQ30; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_QUAT;
      ST_QUAT:   if (step_q == 5'd4) state_d = ST_VSETUP;
      ST_VSETUP: state_d = (cx_q == '0 && cy_q == '0) ? ST_YAW : ST_VEC;
      ST_VEC:    if (step_q == LastStep) state_d = ST_YAW;
      ST_YAW:    state_d = goal_q ? ST_ERR : ST_QUAT;
      ST_ERR:    state_d = ST_PID;
      ST_PID:    if (step_q == 5'd4 && axis_q == 2'd2) state_d = ST_DIST;
      ST_DIST:   if (step_q == 5'd3) state_d = reached_d ? ST_DONE : ST_RSETUP;
      ST_RSETUP: state_d = ST_ROT;
      ST_ROT:    if (step_q == LastStep) state_d = ST_SCALE;
      ST_SCALE:  if (step_q == 5'd2) state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    step_d      = step_q + 5'd1;
    axis_d      = axis_q;
    goal_d      = goal_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    acc_d       = acc_q;
    yaw_p_d     = yaw_p_q;
    yaw_g_d     = yaw_g_q;
    eth_d       = eth_q;
    err_d       = err_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    ctrl_d      = ctrl_q;
    cclip_d     = cclip_q;
    flag_d      = flag_q;
    reached_d   = reached_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    khi         = '0;
    pid_sum     = '0;
    ctrl_full   = '0;
    dx          = '0;
    dy          = '0;
    zr          = '0;
    eth_w       = '0;
    eth_abs     = '0;
    d2          = '0;
    s_a         = '0;
    s_b         = '0;

    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        goal_d = 1'b0;
        flag_d = 1'b0;
      end

      // quaternion products into CORDIC vector
      ST_QUAT: begin
        unique case (step_q)
          5'd1: acc_d = prod_q[63:0];
          5'd2: cy_d  = XyW'((acc_q + prod_q[63:0]) <<< 1);
          5'd3: acc_d = prod_q[63:0];
          5'd4: begin
            cx_d   = XyW'(64'sd268435456 - ((acc_q + prod_q[63:0]) <<< 1));
            step_d = '0;
          end
          default: ;
        endcase
      end

      // fold left half plane, zero vector gives yaw zero
      ST_VSETUP: begin
        step_d = '0;
        cz_d   = '0;
        if (cx_q < 0) begin
          cz_d = (cy_q >= 0) ? PiQ24 : -PiQ24;
          cx_d = -cx_q;
          cy_d = -cy_q;
        end
      end

      ST_VEC, ST_ROT: begin
        if (arm_a) begin
          cx_d = cx_q + sy;
          cy_d = cy_q - sx;
          cz_d = cz_q + at;
        end else begin
          cx_d = cx_q - sy;
          cy_d = cy_q + sx;
          cz_d = cz_q - at;
        end
        if (step_q == LastStep) step_d = '0;
      end

      // round angle to Q3.13
      ST_YAW: begin
        step_d = '0;
        if (goal_q) yaw_g_d = YawW'((cz_q + 28'sd1024) >>> 11);
        else        yaw_p_d = YawW'((cz_q + 28'sd1024) >>> 11);
        goal_d = 1'b1;
      end

      ST_ERR: begin
        dx  = {in_q.goal_x[31], in_q.goal_x} - {in_q.pose_x[31], in_q.pose_x};
        dy  = {in_q.goal_y[31], in_q.goal_y} - {in_q.pose_y[31], in_q.pose_y};
        s_a = sat32(72'(dx));
        s_b = sat32(72'(dy));
        err_d[0] = s_a.val;
        err_d[1] = s_b.val;
        flag_d   = flag_q | s_a.clip | s_b.clip;
        eth_w    = {yaw_g_q[YawW-1], yaw_g_q} - {yaw_p_q[YawW-1], yaw_p_q};
        eth_d    = eth_w[YawW-1:0];
        err_d[2] = 32'(eth_w) <<< 3;
        step_d   = '0;
        axis_d   = '0;
      end

      // PID for one axis over five steps
      ST_PID: begin
        unique case (step_q)
          5'd0: begin
            if (isum > 49'sd140737488355327) begin
              integ_d[axis_q] = 48'sh7fffffffffff;
              flag_d = 1'b1;
            end else if (isum < -49'sd140737488355328) begin
              integ_d[axis_q] = 48'sh800000000000;
              flag_d = 1'b1;
            end else begin
              integ_d[axis_q] = isum[47:0];
            end
          end
          5'd1: begin
            acc_d = prod_q[63:0];
            prev_d[axis_q] = e_sel;
          end
          5'd2, 5'd3: acc_d = acc_q + prod_q[63:0];
          5'd4: begin
            if (prod_q > KiHiLim)       khi = 40'sd274877906944;
            else if (prod_q < -KiHiLim) khi = -40'sd274877906944;
            else                        khi = prod_q[39:0];
            pid_sum   = acc_q + (64'(khi) <<< 24);
            ctrl_full = pid_sum >>> GAIN_FRAC_BITS;
            if (axis_q == 2'd2) s_a = sat32(72'(-ctrl_full));
            else                s_a = sat32(72'(ctrl_full));
            ctrl_d[axis_q]  = s_a.val;
            cclip_d[axis_q] = s_a.clip;
            step_d = '0;
            axis_d = axis_q + 2'd1;
          end
          default: ;
        endcase
      end

      // squared distance against squared tolerance
      ST_DIST: begin
        unique case (step_q)
          5'd1: acc_d = prod_q[63:0];
          5'd2: acc_d = acc_q + prod_q[63:0];
          5'd3: begin
            d2        = acc_q;
            eth_abs   = eth_q[YawW-1] ? YawW'(-eth_q) : eth_q;
            reached_d = (d2 <= prod_q[63:0]) && (eth_abs <= {2'b00, atol_q});
            step_d    = '0;
          end
          default: ;
        endcase
      end

      // body-frame rotation setup, fold into the right half plane
      ST_RSETUP: begin
        step_d = '0;
        flag_d = flag_q | (|cclip_q);
        zr     = -(ZW'(yaw_p_q) <<< 11);
        cx_d   = XyW'(ctrl_q[0]);
        cy_d   = XyW'(ctrl_q[1]);
        cz_d   = zr;
        if (zr > HalfPiQ24) begin
          cx_d = -XyW'(ctrl_q[0]);
          cy_d = -XyW'(ctrl_q[1]);
          cz_d = zr - PiQ24;
        end else if (zr < -HalfPiQ24) begin
          cx_d = -XyW'(ctrl_q[0]);
          cy_d = -XyW'(ctrl_q[1]);
          cz_d = zr + PiQ24;
        end
      end

      // CORDIC gain correction
      ST_SCALE: begin
        s_a = sat32(72'(prod_q >>> 30));
        if (step_q == 5'd1) begin
          vx_d   = s_a.val;
          flag_d = flag_q | s_a.clip;
        end else if (step_q == 5'd2) begin
          vy_d   = s_a.val;
          flag_d = flag_q | s_a.clip;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.reached      = reached_q;
          out_d.saturated    = flag_q;
          out_d.velocity_x   = reached_q ? '0 : vx_q;
          out_d.velocity_y   = reached_q ? '0 : vy_q;
          out_d.angular_rate = reached_q ? '0 : ctrl_q[2];
        end
      end

      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      axis_q      <= '0;
      goal_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      ptol_q      <= 16'd655;
      atol_q      <= 15'd164;
      for (int i = 0; i < 3; i++) begin
        integ_q[i] <= '0;
        prev_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      goal_q      <= goal_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_KP:      kp_q   <= cfg_data_i;
          REG_KI:      ki_q   <= cfg_data_i;
          REG_KD:      kd_q   <= cfg_data_i;
          REG_POS_TOL: ptol_q <= cfg_data_i[15:0];
          REG_ANG_TOL: atol_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    prod_q    <= mul_a * mul_b;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cz_q      <= cz_d;
    acc_q     <= acc_d;
    yaw_p_q   <= yaw_p_d;
    yaw_g_q   <= yaw_g_d;
    eth_q     <= eth_d;
    err_q     <= err_d;
    ctrl_q    <= ctrl_d;
    cclip_q   <= cclip_d;
    flag_q    <= flag_d;
    reached_q <= reached_d;
    vx_q      <= vx_d;
    vy_q      <= vy_d;
    out_q     <= out_d;
  end

  // checks
  `HPPC_ASSERT_NOW(a_reached_zero, out_valid_o && out_data_o.reached,
    out_data_o.velocity_x == '0 && out_data_o.velocity_y == '0 &&
    out_data_o.angular_rate == '0, "reached word carries nonzero command")
  `HPPC_ASSERT_NXT(a_busy_after_take, in_valid_i && in_ready_o,
    !in_ready_o, "block still ready after taking a word")
  `HPPC_ASSERT_NXT(a_done_loads, state_q == ST_DONE && !out_valid_q,
    out_valid_q && state_q == ST_IDLE, "finished word not loaded")

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the go-to-pose PID controller
`timescale 1ns / 100ps

module tb_top;
  import hppc_pkg::*;

  localparam int unsigned Steps     = 16;
  localparam int unsigned FracBits  = 10;
  localparam int unsigned NumRandom = 1850;
  localparam int unsigned PhaseLen  = 300;
  localparam int unsigned Latency   = 120;
  localparam longint      CycleLimit = 64'd1500000;

  localparam longint I32Max = 64'sd2147483647;
  localparam longint I32Min = -64'sd2147483648;
  localparam longint I48Max = 64'sd140737488355327;
  localparam longint I48Min = -64'sd140737488355328;
  localparam longint PiQ    = 64'sd52707179;
  localparam longint HalfPiQ = 64'sd26353589;
  localparam longint InvGain = 64'sd652032874;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  hppc_in_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  hppc_out_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // predictor state and register copies
  logic [59:0] kp_regs, ki_regs, kd_regs;
  logic [15:0] pos_tol;
  logic [14:0] ang_tol;
  longint      integ_acc [3];
  longint      prev_err  [3];

  hppc_out_t command_queue [$];
  bit        failed;
  bit        out_idle_on;
  bit        in_idle_on;
  longint    cycle_count;

  holonomic_pose_pid_controller #(
    .CORDIC_STEPS  (Steps),
    .GAIN_FRAC_BITS(FracBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // floor shift for signed values
  function automatic longint shr_floor(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, ref bit f);
    if (v > hi) begin
      f = 1'b1;
      return hi;
    end
    if (v < lo) begin
      f = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // quaternion to yaw in Q3.13 via vectoring CORDIC
  function automatic longint quat_yaw(longint qx, longint qy, longint qz, longint qw);
    longint yv, xv, zv, nx, ny;
    yv = 2 * (qz * qw + qx * qy);
    xv = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
    zv = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      zv = (yv >= 0) ? PiQ : -PiQ;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < Steps; i++) begin
      if (yv > 0) begin
        nx = xv + shr_floor(yv, i);
        ny = yv - shr_floor(xv, i);
        zv += longint'(atan_q24(i[4:0]));
      end else begin
        nx = xv - shr_floor(yv, i);
        ny = yv + shr_floor(xv, i);
        zv -= longint'(atan_q24(i[4:0]));
      end
      xv = nx;
      yv = ny;
    end
    return shr_floor(zv + 1024, 11);
  endfunction

  // one axis of PID, updating integrator and previous error
  function automatic longint axis_pid(int axis, longint e, ref bit f);
    longint kp, ki, kd, acc, hi, lo;
    bit unused;
    kp = longint'(kp_regs[20*axis +: 20]);
    ki = longint'(ki_regs[20*axis +: 20]);
    kd = longint'(kd_regs[20*axis +: 20]);
    integ_acc[axis] = clamp(integ_acc[axis] + e, I48Min, I48Max, f);
    acc = kp * e + kd * (e - prev_err[axis]);
    prev_err[axis] = e;
    hi = shr_floor(integ_acc[axis], 24);
    lo = integ_acc[axis] - hi * (64'sd1 << 24);
    acc += ki * lo;
    unused = 1'b0;
    hi = clamp(ki * hi, -(64'sd1 << 38), 64'sd1 << 38, unused);
    acc += hi * (64'sd1 << 24);
    return shr_floor(acc, FracBits);
  endfunction

  // expected command for one pose word
  function automatic hppc_out_t predict_command(hppc_in_t w);
    hppc_out_t r;
    bit f, at_goal;
    longint pyaw, gyaw, ex, ey, eth, cx, cy, cth, aeth, xv, yv, zv, nx, ny;
    logic [63:0] d2, t2;
    f = 1'b0;
    pyaw = quat_yaw(w.pose_qx, w.pose_qy, w.pose_qz, w.pose_qw);
    gyaw = quat_yaw(w.goal_qx, w.goal_qy, w.goal_qz, w.goal_qw);
    ex = clamp(longint'(w.goal_x) - longint'(w.pose_x), I32Min, I32Max, f);
    ey = clamp(longint'(w.goal_y) - longint'(w.pose_y), I32Min, I32Max, f);
    eth = gyaw - pyaw;
    cx = axis_pid(0, ex, f);
    cy = axis_pid(1, ey, f);
    cth = axis_pid(2, eth * 8, f);
    d2 = 64'(ex * ex) + 64'(ey * ey);
    t2 = 64'(pos_tol) * 64'(pos_tol);
    aeth = eth < 0 ? -eth : eth;
    at_goal = (d2 <= t2) && (aeth <= longint'(ang_tol));
    r = '0;
    if (!at_goal) begin
      xv = clamp(cx, I32Min, I32Max, f);
      yv = clamp(cy, I32Min, I32Max, f);
      zv = -(pyaw * 2048);
      if (zv > HalfPiQ) begin
        xv = -xv; yv = -yv; zv -= PiQ;
      end else if (zv < -HalfPiQ) begin
        xv = -xv; yv = -yv; zv += PiQ;
      end
      for (int i = 0; i < Steps; i++) begin
        if (zv >= 0) begin
          nx = xv - shr_floor(yv, i);
          ny = yv + shr_floor(xv, i);
          zv -= longint'(atan_q24(i[4:0]));
        end else begin
          nx = xv + shr_floor(yv, i);
          ny = yv - shr_floor(xv, i);
          zv += longint'(atan_q24(i[4:0]));
        end
        xv = nx;
        yv = ny;
      end
      r.velocity_x   = 32'(clamp(shr_floor(xv * InvGain, 30), I32Min, I32Max, f));
      r.velocity_y   = 32'(clamp(shr_floor(yv * InvGain, 30), I32Min, I32Max, f));
      r.angular_rate = 32'(clamp(-cth, I32Min, I32Max, f));
    end
    r.reached   = at_goal;
    r.saturated = f;
    return r;
  endfunction

  // random gaps on the sending side; the config channel idles meanwhile
  task automatic sender_gap();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    while (in_idle_on && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // returns at the accepting edge
  task automatic send_word(hppc_in_t w);
    sender_gap();
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    command_queue.push_back(predict_command(w));
  endtask

  // returns at the accepting edge
  task automatic write_reg(hppc_reg_e idx, logic [59:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_KP:      kp_regs = val;
      REG_KI:      ki_regs = val;
      REG_KD:      kd_regs = val;
      REG_POS_TOL: pos_tol = val[15:0];
      REG_ANG_TOL: ang_tol = val[14:0];
      default: ;
    endcase
  endtask

  // wait until every command has come back, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (command_queue.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  // modest gains half the time, otherwise one of the extremes
  function automatic logic [59:0] pick_gains();
    logic [59:0] g;
    for (int a = 0; a < 3; a++) begin
      case ($urandom_range(3))
        0:       g[20*a +: 20] = '1;
        1:       g[20*a +: 20] = '0;
        default: g[20*a +: 20] = 20'($urandom_range(4096));
      endcase
    end
    return g;
  endfunction

  function automatic logic signed [15:0] rand_q(bit unit);
    if (unit) return 16'(int'($urandom_range(32768)) - 16384);
    return 16'($urandom);
  endfunction

  function automatic hppc_in_t rand_word();
    hppc_in_t w;
    bit unit, near;
    unit = $urandom_range(3) != 0;
    near = $urandom_range(4) == 0;
    w.pose_x  = ($urandom_range(3) == 0) ? 32'($urandom) : 32'(int'($urandom_range(2000000)) - 1000000);
    w.pose_y  = ($urandom_range(3) == 0) ? 32'($urandom) : 32'(int'($urandom_range(2000000)) - 1000000);
    w.goal_x  = near ? w.pose_x + 32'(int'($urandom_range(800)) - 400)
                     : (($urandom_range(3) == 0) ? 32'($urandom) : 32'(int'($urandom_range(2000000)) - 1000000));
    w.goal_y  = near ? w.pose_y + 32'(int'($urandom_range(800)) - 400)
                     : (($urandom_range(3) == 0) ? 32'($urandom) : 32'(int'($urandom_range(2000000)) - 1000000));
    w.pose_qx = rand_q(unit);
    w.pose_qy = rand_q(unit);
    w.pose_qz = rand_q(unit);
    w.pose_qw = rand_q(unit);
    if (near) begin
      w.goal_qx = w.pose_qx;
      w.goal_qy = w.pose_qy;
      w.goal_qz = w.pose_qz;
      w.goal_qw = w.pose_qw + 16'($urandom_range(8));
    end else begin
      w.goal_qx = rand_q(unit);
      w.goal_qy = rand_q(unit);
      w.goal_qz = rand_q(unit);
      w.goal_qw = rand_q(unit);
    end
    return w;
  endfunction

  // result checker with random back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= !(out_idle_on && $urandom_range(99) < 38);
  end

  always @(posedge clk_i) begin
    hppc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (command_queue.size() == 0) begin
        $display("%0t: unexpected command word %h", $time, out_data_o);
        failed = 1'b1;
      end else begin
        want = command_queue.pop_front();
        if (out_data_o.velocity_x !== want.velocity_x) begin
          $display("%0t: velocity_x expected %0d got %0d", $time, want.velocity_x,
                   out_data_o.velocity_x);
          failed = 1'b1;
        end
        if (out_data_o.velocity_y !== want.velocity_y) begin
          $display("%0t: velocity_y expected %0d got %0d", $time, want.velocity_y,
                   out_data_o.velocity_y);
          failed = 1'b1;
        end
        if (out_data_o.angular_rate !== want.angular_rate) begin
          $display("%0t: angular_rate expected %0d got %0d", $time, want.angular_rate,
                   out_data_o.angular_rate);
          failed = 1'b1;
        end
        if (out_data_o.reached !== want.reached) begin
          $display("%0t: reached expected %b got %b", $time, want.reached, out_data_o.reached);
          failed = 1'b1;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b got %b", $time, want.saturated,
                   out_data_o.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  typedef struct {
    hppc_in_t  word;
    bit        known;
    hppc_out_t result;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic hppc_in_t mk(int px, int py, int gx, int gy,
                                  shortint pz, shortint pw, shortint gz, shortint gw);
    hppc_in_t w;
    w = '0;
    w.pose_x = px; w.pose_y = py; w.goal_x = gx; w.goal_y = gy;
    w.pose_qz = pz; w.pose_qw = pw; w.goal_qz = gz; w.goal_qw = gw;
    return w;
  endfunction

  initial begin
    hppc_out_t zero_reached;
    hppc_in_t  w;
    failed      = 1'b0;
    cycle_count = 0;
    out_idle_on = 1'b0;
    in_idle_on  = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_KP;
    cfg_data_i  = '0;
    kp_regs = '0; ki_regs = '0; kd_regs = '0;
    pos_tol = 16'd655; ang_tol = 15'd164;
    for (int a = 0; a < 3; a++) begin
      integ_acc[a] = 0;
      prev_err[a]  = 0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // after reset: gains zero, pose on goal gives zero output and reached
    zero_reached = '0;
    zero_reached.reached = 1'b1;
    directed.push_back('{mk(0, 0, 0, 0, 0, 16384, 0, 16384), 1'b1, zero_reached});
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_reached});
    directed.push_back('{mk(1000, -1000, 1000, -1000, 11585, 11585, 11585, 11585),
                         1'b1, zero_reached});
    foreach (directed[i]) begin
      if (directed[i].known) begin
        send_word(directed[i].word);
        void'(command_queue.pop_back());
        command_queue.push_back(directed[i].result);
      end
    end
    drain();

    // full proportional gains and extreme words, checked against the predictor
    write_reg(REG_KP, '1);
    write_reg(REG_KI, 60'h00100_00100_00100);
    write_reg(REG_KD, 60'h00400_00400_00400);
    write_reg(REG_POS_TOL, 16'hffff);
    write_reg(REG_ANG_TOL, 15'h7fff);
    write_reg(hppc_reg_e'(3'd7), '1);
    directed.delete();
    directed.push_back('{mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                            16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff), 1'b0, '0});
    directed.push_back('{mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                            16384, 0, -16384, 0), 1'b0, '0});
    directed.push_back('{mk(0, 0, 100, 100, 0, 16384, 0, 16384), 1'b0, '0});
    directed.push_back('{mk(0, 0, 65536, 0, 16384, 0, 0, 16384), 1'b0, '0});
    directed.push_back('{mk(5, 5, -5, -5, -16384, 0, 16384, 0), 1'b0, '0});
    directed.push_back('{mk(0, 0, 0, 0, 0, 0, 11585, -11585), 1'b0, '0});
    w = '1;
    directed.push_back('{w, 1'b0, '0});
    directed.push_back('{hppc_in_t'('0), 1'b0, '0});
    foreach (directed[i]) send_word(directed[i].word);
    drain();
    write_reg(REG_POS_TOL, '0);
    write_reg(REG_ANG_TOL, '0);
    send_word(mk(0, 0, 0, 0, 0, 16384, 0, 16384));
    send_word(mk(0, 0, 1, 0, 0, 16384, 0, 16384));
    drain();

    // random phases with fresh settings between them
    for (int n = 0; n < NumRandom; n++) begin
      if (n % PhaseLen == 0) begin
        drain();
        write_reg(REG_KP, pick_gains());
        write_reg(REG_KI, pick_gains());
        write_reg(REG_KD, pick_gains());
        write_reg(REG_POS_TOL, 16'($urandom_range(3) == 0 ? $urandom : $urandom_range(1000)));
        write_reg(REG_ANG_TOL, 15'($urandom_range(3) == 0 ? $urandom : $urandom_range(400)));
      end
      // a stretch without random gaps or back-pressure in the middle of each phase
      in_idle_on  = (n % PhaseLen) < 100 || (n % PhaseLen) >= 200;
      out_idle_on = in_idle_on;
      send_word(rand_word());
    end

    drain();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
